FILE: hdl/trfs_pkg.sv
// Shared types and constants for the thread ready queue with id search.
package trfs_pkg;

   localparam int FIELD_W         = 16;
   localparam int OCC_W           = 5;
   localparam int CMD_W           = 2;
   localparam int STATUS_W        = 2;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_WIDTH    = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_FIND = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                 valid;
      status_type           status;
      logic [FIELD_W-1:0]   handle;
      logic [FIELD_W-1:0]   entry_id;
      logic [OCC_W-1:0]     occupancy;
      logic                 is_empty;
   } resp_type;

endpackage

FILE: hdl/trfs_entry_ram.sv
// Entry storage: one write port, one registered read port.
module trfs_entry_ram import trfs_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   parameter int WIDTH = 2 * FIELD_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/trfs_seq.sv
// Command sequencer: ring pointers, occupancy and the serial id compare.
module trfs_seq import trfs_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [FIELD_W-1:0] req_thread_id,
   input  logic [FIELD_W-1:0] req_handle,
   output resp_type           res,
   input  logic               res_take
);

   localparam int IdBits = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;
   localparam int IdxW   = $clog2(QUEUE_DEPTH);
   localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
   localparam int EntW   = IdBits + FIELD_W;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IdBits-1:0]  key_ff, key_in;
   logic [FIELD_W-1:0] hdl_ff, hdl_in;
   logic [IdxW-1:0]    head_ff, head_in;
   logic [IdxW-1:0]    tail_ff, tail_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [IdxW-1:0]    pos_ff, pos_in;
   logic [CntW-1:0]    left_ff, left_in;
   status_type         res_status_ff, res_status_in;
   logic [FIELD_W-1:0] res_handle_ff, res_handle_in;
   logic [FIELD_W-1:0] res_id_ff, res_id_in;

   logic               wr_en;
   logic               done_valid;
   logic [EntW-1:0]    rd_data;
   logic [IdBits-1:0]  rd_id;
   logic [FIELD_W-1:0] rd_handle;

   function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
      return (i == IdxW'(QUEUE_DEPTH - 1)) ? '0 : i + IdxW'(1);
   endfunction

   trfs_entry_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EntW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data ({key_ff, hdl_ff}),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   assign rd_id     = rd_data[EntW-1:FIELD_W];
   assign rd_handle = rd_data[FIELD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      hdl_ff        <= hdl_in;
      pos_ff        <= pos_in;
      left_ff       <= left_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_id_ff     <= res_id_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      hdl_in        = hdl_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_id_in     = res_id_ff;
      wr_en         = 1'b0;
      req_ready     = 1'b0;
      done_valid    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               key_in   = req_thread_id[IdBits-1:0];
               hdl_in   = req_handle;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = STAT_OK;
            res_handle_in = '0;
            res_id_in     = '0;
            pos_in        = head_ff;
            left_in       = count_ff;
            state_in      = S_DONE;
            unique case (cmd_ff) inside
               CMD_ENQ: begin
                  if (count_ff == CntW'(QUEUE_DEPTH)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = next_idx(tail_ff);
                     count_in = count_ff + CntW'(1);
                  end
               end
               CMD_DEQ, CMD_FIND: begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_MISS;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // dequeue takes the head entry unconditionally
            if (cmd_ff == CMD_DEQ || rd_id == key_ff) begin
               res_id_in     = FIELD_W'(rd_id);
               res_handle_in = rd_handle;
               state_in      = S_DONE;
               if (cmd_ff == CMD_DEQ) begin
                  head_in  = next_idx(head_ff);
                  count_in = count_ff - CntW'(1);
               end
            end else if (left_ff == CntW'(1)) begin
               res_status_in = STAT_MISS;
               state_in      = S_DONE;
            end else begin
               pos_in  = next_idx(pos_ff);
               left_in = left_ff - CntW'(1);
            end
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.valid     = done_valid;
   assign res.status    = res_status_ff;
   assign res.handle    = res_handle_ff;
   assign res.entry_id  = res_id_ff;
   assign res.occupancy = OCC_W'(count_ff);
   assign res.is_empty  = (count_ff == '0);

endmodule

FILE: hdl/thread_ready_fifo_with_id_search_unit.sv
// Top level of the thread ready queue with id search.
//
// Bounded FIFO of QUEUE_DEPTH (thread id, handle) entries kept in a ring
// buffer RAM with one write and one registered read port. Enqueue, and a
// dequeue or lookup on an empty queue, go from the execute state straight
// to the done state; a dequeue from a non-empty queue passes through the
// scan state on the head entry. Lookup walks the RAM read port one entry
// per cycle from the oldest entry, up to the first match or, on a miss,
// through the whole occupancy. One request is in work at a time; a
// finished result sits in an output register, and the next request is
// accepted while it waits. When that register is still held by a low
// rsp_ready, the next finished result waits in the sequencer and the input
// stalls until the register frees. Thread ids are compared on their low
// ID_WIDTH bits (at most FIELD_W).
module thread_ready_fifo_with_id_search_unit import trfs_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [FIELD_W-1:0]  req_thread_id,
   input  logic [FIELD_W-1:0]  req_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_out_handle,
   output logic [FIELD_W-1:0]  rsp_out_thread_id,
   output logic [OCC_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty
);

   resp_type            res;
   logic                res_take;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [FIELD_W-1:0]  handle_ff;
   logic [FIELD_W-1:0]  id_ff;
   logic [OCC_W-1:0]    occ_ff;
   logic                empty_ff;

   trfs_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_thread_id (req_thread_id),
      .req_handle    (req_handle),
      .res           (res),
      .res_take      (res_take)
   );

   assign res_take = res.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         status_ff <= res.status;
         handle_ff <= res.handle;
         id_ff     <= res.entry_id;
         occ_ff    <= res.occupancy;
         empty_ff  <= res.is_empty;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_handle    = handle_ff;
   assign rsp_out_thread_id = id_ff;
   assign rsp_occupancy     = occ_ff;
   assign rsp_is_empty      = empty_ff;

endmodule
